@@ sv/aobp_pkg.sv @@
// ----------------------------------------------------------------------------
// aobp_pkg
// Shared widths, register indexes, types and channel arithmetic for the
// premultiplied argb over blend and device repack block.
// ----------------------------------------------------------------------------
package aobp_pkg;

    localparam int CHAN_W      = 8;
    localparam int PIXEL_W     = 32;
    localparam int OPACITY_W   = 9;
    localparam int LEN_W       = 4;
    localparam int POS_W       = 5;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 5;
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RED_LENGTH     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_LENGTH   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_LENGTH    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_LENGTH   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RED_POSITION   = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_POSITION = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_POSITION  = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_POSITION = 4'd7;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;
    localparam logic [LEN_W-1:0]  LEN_MAX  = 4'd8;

    // device layout registers
    typedef struct packed {
        logic [LEN_W-1:0] red_length;
        logic [LEN_W-1:0] green_length;
        logic [LEN_W-1:0] blue_length;
        logic [LEN_W-1:0] alpha_length;
        logic [POS_W-1:0] red_position;
        logic [POS_W-1:0] green_position;
        logic [POS_W-1:0] blue_position;
        logic [POS_W-1:0] alpha_position;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        red_length:     4'd8,
        green_length:   4'd8,
        blue_length:    4'd8,
        alpha_length:   4'd8,
        red_position:   5'd16,
        green_position: 5'd8,
        blue_position:  5'd0,
        alpha_position: 5'd24
    };

    // one queued transaction: opacity-scaled source plus destination
    typedef struct packed {
        logic [PIXEL_W-1:0] src_scaled;
        logic [PIXEL_W-1:0] dst;
    } item_t;

    // channel times opacity over 256, saturating
    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                     input logic [OPACITY_W-1:0] op);
        logic [CHAN_W+OPACITY_W-1:0] prod;
        logic [OPACITY_W-1:0]        shifted;
        prod    = {{OPACITY_W{1'b0}}, c} * {{CHAN_W{1'b0}}, op};
        shifted = prod[CHAN_W+OPACITY_W-1:CHAN_W];
        return (shifted > {1'b0, CHAN_MAX}) ? CHAN_MAX : shifted[CHAN_W-1:0];
    endfunction

    // exact floor(x / 255) for x up to 255 * 255
    function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
        logic [2*CHAN_W:0] t;
        t = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[2*CHAN_W-1:CHAN_W]} + {{(2*CHAN_W){1'b0}}, 1'b1};
        return t[2*CHAN_W-1:CHAN_W];
    endfunction

    // source plus weighted destination, saturating
    function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        logic [CHAN_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
    endfunction

    // keep the top len bits of a channel and move them up to pos
    function automatic logic [PIXEL_W-1:0] pack_chan(input logic [CHAN_W-1:0] c,
                                                     input logic [LEN_W-1:0]  len,
                                                     input logic [POS_W-1:0]  pos);
        logic [LEN_W-1:0]  l;
        logic [CHAN_W-1:0] kept;
        l    = (len > LEN_MAX) ? LEN_MAX : len;
        kept = c >> (LEN_MAX - l);
        return {{(PIXEL_W-CHAN_W){1'b0}}, kept} << pos;
    endfunction

endpackage

@@ sv/argb_over_blend_and_pack.sv @@
// ----------------------------------------------------------------------------
// argb_over_blend_and_pack
// Premultiplied argb32 over compositing with opacity and device repacking.
//
// Input channel: in_valid / in_stall with source_pixel, dest_pixel and
// opacity (1/256 units). Output channel: out_valid / out_stall with
// blended_pixel and device_pixel. A transaction moves on a clock edge where
// valid is high and stall is low.
// Throughput is one pixel per clock while out_stall is low. From an input
// transaction to out_valid when the block is empty, the queue register is
// loaded at the accepting edge, then the multiply stage register and then
// the divide/repack output register.
// When the receiver stalls, the output register holds its result and the
// back pipeline freezes; the queue (QUEUE_DEPTH entries) keeps taking input
// until it is full, and only then is in_stall raised.
// The layout registers are written through cfg_write_en / cfg_index /
// cfg_data and should only change while no transaction is in flight.
// Reset clears the queue and the pipeline valids and loads the default
// layout: 8 bits per channel, alpha at 24, red at 16, green at 8, blue at 0.
// ----------------------------------------------------------------------------
module argb_over_blend_and_pack #(
    parameter int QUEUE_DEPTH = aobp_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [aobp_pkg::PIXEL_W-1:0]     source_pixel,
    input  logic [aobp_pkg::PIXEL_W-1:0]     dest_pixel,
    input  logic [aobp_pkg::OPACITY_W-1:0]   opacity,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [aobp_pkg::PIXEL_W-1:0]     blended_pixel,
    output logic [aobp_pkg::PIXEL_W-1:0]     device_pixel,
    input  logic                             cfg_write_en,
    input  logic [aobp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [aobp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import aobp_pkg::*;

    cfg_t  cfg_reg;
    item_t push_item, pop_item;
    logic  q_push, q_full, q_pop, q_valid;

    // layout registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_RED_LENGTH:     cfg_reg.red_length     <= cfg_data[LEN_W-1:0];
                CFG_GREEN_LENGTH:   cfg_reg.green_length   <= cfg_data[LEN_W-1:0];
                CFG_BLUE_LENGTH:    cfg_reg.blue_length    <= cfg_data[LEN_W-1:0];
                CFG_ALPHA_LENGTH:   cfg_reg.alpha_length   <= cfg_data[LEN_W-1:0];
                CFG_RED_POSITION:   cfg_reg.red_position   <= cfg_data[POS_W-1:0];
                CFG_GREEN_POSITION: cfg_reg.green_position <= cfg_data[POS_W-1:0];
                CFG_BLUE_POSITION:  cfg_reg.blue_position  <= cfg_data[POS_W-1:0];
                CFG_ALPHA_POSITION: cfg_reg.alpha_position <= cfg_data[POS_W-1:0];
                default:            ;
            endcase
        end
    end

    // front: accept and scale
    aobp_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .source_pixel (source_pixel),
        .dest_pixel   (dest_pixel),
        .opacity      (opacity),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    // decoupling queue
    aobp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .pop_item  (pop_item)
    );

    // back: composite and repack
    aobp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .cfg           (cfg_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .blended_pixel (blended_pixel),
        .device_pixel  (device_pixel)
    );

endmodule

@@ sv/aobp_front.sv @@
// ----------------------------------------------------------------------------
// aobp_front
// Input side: takes a transaction, scales the four source channels by the
// opacity and pushes the result with the destination pixel into the queue.
// ----------------------------------------------------------------------------
module aobp_front (
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [aobp_pkg::PIXEL_W-1:0]       source_pixel,
    input  logic [aobp_pkg::PIXEL_W-1:0]       dest_pixel,
    input  logic [aobp_pkg::OPACITY_W-1:0]     opacity,
    input  logic                               q_full,
    output logic                               q_push,
    output aobp_pkg::item_t                    q_item
);
    import aobp_pkg::*;

    // back-pressure comes only from a full queue
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // opacity scaling, one multiplier per channel
    always_comb
    begin
        q_item.src_scaled[31:24] = scale_chan(source_pixel[31:24], opacity);
        q_item.src_scaled[23:16] = scale_chan(source_pixel[23:16], opacity);
        q_item.src_scaled[15:8]  = scale_chan(source_pixel[15:8],  opacity);
        q_item.src_scaled[7:0]   = scale_chan(source_pixel[7:0],   opacity);
        q_item.dst               = dest_pixel;
    end

endmodule

@@ sv/aobp_queue.sv @@
// ----------------------------------------------------------------------------
// aobp_queue
// Short register queue between the front and back parts so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module aobp_queue #(
    parameter int DEPTH = aobp_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  aobp_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output aobp_pkg::item_t pop_item
);
    import aobp_pkg::*;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

    item_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == COUNT_FULL);
    assign q_valid  = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;
    assign pop_item = mem[rd_ptr_reg];

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/aobp_back.sv @@
// ----------------------------------------------------------------------------
// aobp_back
// Output side: two-stage pipeline that weights the destination by the
// inverse source alpha, adds the source, saturates and repacks the result
// into the device layout. The output register holds while stalled.
// ----------------------------------------------------------------------------
module aobp_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  aobp_pkg::item_t              q_item,
    output logic                         q_pop,
    input  aobp_pkg::cfg_t               cfg,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [aobp_pkg::PIXEL_W-1:0] blended_pixel,
    output logic [aobp_pkg::PIXEL_W-1:0] device_pixel
);
    import aobp_pkg::*;

    logic                  advance;
    logic                  s1_valid_reg;
    logic [PIXEL_W-1:0]    s1_src_reg;
    logic [2*CHAN_W-1:0]   s1_prod_reg [4];
    logic [2*CHAN_W-1:0]   prod_next [4];
    logic [CHAN_W-1:0]     inv_alpha;
    logic [CHAN_W-1:0]     oa, orr, og, ob;
    logic [PIXEL_W-1:0]    blended_next, device_next;
    logic                  out_valid_reg;
    logic [PIXEL_W-1:0]    blended_reg, device_reg;

    // whole pipeline moves unless a held result is being stalled
    assign advance = !out_valid_reg || !out_stall;
    assign q_pop   = advance && q_valid;

    // stage 1: destination times inverse source alpha
    always_comb
    begin
        inv_alpha = CHAN_MAX - q_item.src_scaled[31:24];
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = {{CHAN_W{1'b0}}, q_item.dst[i*CHAN_W +: CHAN_W]}
                         * {{CHAN_W{1'b0}}, inv_alpha};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && q_valid)
        begin
            s1_src_reg <= q_item.src_scaled;
            for (int i = 0; i < 4; i++)
            begin
                s1_prod_reg[i] <= prod_next[i];
            end
        end
    end

    // stage 2: divide by 255, add source, saturate, repack
    always_comb
    begin
        ob  = sat_add(s1_src_reg[7:0],   div255(s1_prod_reg[0]));
        og  = sat_add(s1_src_reg[15:8],  div255(s1_prod_reg[1]));
        orr = sat_add(s1_src_reg[23:16], div255(s1_prod_reg[2]));
        oa  = sat_add(s1_src_reg[31:24], div255(s1_prod_reg[3]));
        blended_next = {oa, orr, og, ob};
        device_next  = pack_chan(oa,  cfg.alpha_length, cfg.alpha_position)
                     | pack_chan(orr, cfg.red_length,   cfg.red_position)
                     | pack_chan(og,  cfg.green_length, cfg.green_position)
                     | pack_chan(ob,  cfg.blue_length,  cfg.blue_position);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            blended_reg <= blended_next;
            device_reg  <= device_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign blended_pixel = blended_reg;
    assign device_pixel  = device_reg;

endmodule

@@ sv/aobp_checker.sv @@
// ----------------------------------------------------------------------------
// aobp_checker
// Port-level checks on the blend block, bound to the top level.
// ----------------------------------------------------------------------------
module aobp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] blended_pixel,
    input logic [31:0] device_pixel
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(blended_pixel)
                                   && $stable(device_pixel))
        else $error("stalled result changed");

    // nothing is offered once reset has taken hold
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("activity during reset");

    // input back-pressure only arises behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    // a full queue only drains through an output transaction
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !(out_valid && !out_stall) |=> in_stall)
        else $error("input stall released without draining");

endmodule

bind argb_over_blend_and_pack aobp_checker u_aobp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .blended_pixel (blended_pixel),
    .device_pixel  (device_pixel)
);

@@ tb/sv/tb_argb_over_blend_and_pack.sv @@
// ----------------------------------------------------------------------------
// tb_argb_over_blend_and_pack
// Self-checking bench for the premultiplied argb over blend and device
// repack block. A table of hand-picked pixels runs first under the reset
// layout, then random pixels run under several device layouts, from
// zero-length fields to fields that cross bit 31 and overlap. Typed table
// results or a local compositing model predict both output pixels of every
// transaction and a monitor compares them in order. Both sides idle at
// random; the receiver holds off once for long enough to fill the block.
// ----------------------------------------------------------------------------
module tb_argb_over_blend_and_pack;

    timeunit 1ns;
    timeprecision 1ps;

    import aobp_pkg::*;

    localparam int N_PHASES        = 7;
    localparam int PIXELS_PER_PHASE = 265;
    localparam int N_DIRECTED      = 20;
    localparam int HOLD_CYCLES     = 64;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int MAX_REPORTS     = 10;
    localparam int SETTLE_CYCLES   = 8;
    localparam int IDLE_PERCENT    = 30;
    localparam int QUIET_PHASE     = 3;

    // register indexes past the layout registers are ignored by the block
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = 4'd8;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST  = 4'd15;

    // layout registers in index order
    localparam logic [CFG_INDEX_W-1:0] LAYOUT_REGS [8] = '{
        CFG_RED_LENGTH, CFG_GREEN_LENGTH, CFG_BLUE_LENGTH, CFG_ALPHA_LENGTH,
        CFG_RED_POSITION, CFG_GREEN_POSITION, CFG_BLUE_POSITION, CFG_ALPHA_POSITION
    };

    // channel order follows the register list
    typedef enum int {CH_RED, CH_GREEN, CH_BLUE, CH_ALPHA} chan_e;
    localparam int ARGB_SHIFT [4] = '{16, 8, 0, 24};

    typedef struct packed {
        logic [PIXEL_W-1:0] blend;
        logic [PIXEL_W-1:0] dev;
    } pixel_result_t;

    typedef struct packed {
        logic [PIXEL_W-1:0]   src;
        logic [PIXEL_W-1:0]   dst;
        logic [OPACITY_W-1:0] op;
        bit                   typed;
        logic [PIXEL_W-1:0]   blend;
        logic [PIXEL_W-1:0]   dev;
    } dir_row_t;

    // hand-picked pixels; typed results hold under the reset layout
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{32'h00000000, 32'h00000000, 9'd0,   1'b1, 32'h00000000, 32'h00000000},
        '{32'hffffffff, 32'h00000000, 9'd256, 1'b1, 32'hffffffff, 32'hffffffff},
        '{32'h00000000, 32'hffffffff, 9'd256, 1'b1, 32'hffffffff, 32'hffffffff},
        '{32'hffffffff, 32'hffffffff, 9'd0,   1'b1, 32'hffffffff, 32'hffffffff},
        '{32'hff000000, 32'hffffffff, 9'd256, 1'b1, 32'hff000000, 32'hff000000},
        '{32'h80402010, 32'h00000000, 9'd256, 1'b1, 32'h80402010, 32'h80402010},
        '{32'h00ffffff, 32'h00ffffff, 9'd256, 1'b1, 32'h00ffffff, 32'h00ffffff},
        '{32'hffffffff, 32'h12345678, 9'd511, 1'b1, 32'hffffffff, 32'hffffffff},
        '{32'h00000000, 32'h12345678, 9'h155, 1'b1, 32'h12345678, 32'h12345678},
        '{32'h01010101, 32'h00000000, 9'd511, 1'b0, 32'h0, 32'h0},
        '{32'h80808080, 32'h80808080, 9'd128, 1'b0, 32'h0, 32'h0},
        '{32'h7f7f7f7f, 32'h00000000, 9'd257, 1'b0, 32'h0, 32'h0},
        '{32'haaaaaaaa, 32'h55555555, 9'h0aa, 1'b0, 32'h0, 32'h0},
        '{32'h55555555, 32'haaaaaaaa, 9'd256, 1'b0, 32'h0, 32'h0},
        '{32'h40302010, 32'hffffffff, 9'd256, 1'b0, 32'h0, 32'h0},
        '{32'h80000000, 32'hffffffff, 9'h1ff, 1'b0, 32'h0, 32'h0},
        '{32'hff102030, 32'h00000000, 9'h080, 1'b0, 32'h0, 32'h0},
        '{32'h01020304, 32'hfefdfcfb, 9'h0ff, 1'b0, 32'h0, 32'h0},
        '{32'hc0a08060, 32'h3f5f7f9f, 9'h0c0, 1'b0, 32'h0, 32'h0},
        '{32'hffff0000, 32'h0000ffff, 9'd1,   1'b0, 32'h0, 32'h0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [PIXEL_W-1:0]     source_pixel = '0;
    logic [PIXEL_W-1:0]     dest_pixel = '0;
    logic [OPACITY_W-1:0]   opacity = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [PIXEL_W-1:0]     blended_pixel;
    logic [PIXEL_W-1:0]     device_pixel;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // local copy of the device layout
    logic [LEN_W-1:0] lay_len [4] = '{4'd8, 4'd8, 4'd8, 4'd8};
    logic [POS_W-1:0] lay_pos [4] = '{5'd16, 5'd8, 5'd0, 5'd24};

    pixel_result_t pending_pixels [$];
    int            mismatches = 0;
    int            pixels_checked = 0;
    int            pixels_sent = 0;
    int            layouts_run = 0;
    int            cycle_count = 0;
    int            hold_left = 0;
    int            holds_asked = 0;
    int            holds_taken = 0;
    bit            quiet = 1'b0;

    argb_over_blend_and_pack u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .source_pixel  (source_pixel),
        .dest_pixel    (dest_pixel),
        .opacity       (opacity),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .blended_pixel (blended_pixel),
        .device_pixel  (device_pixel),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // channel times opacity over 256, saturating
    function automatic int unsigned scale_by_opacity(input logic [7:0] c,
                                                     input logic [OPACITY_W-1:0] op);
        int unsigned p;
        p = (int'(c) * int'(op)) >> 8;
        return (p > 255) ? 255 : p;
    endfunction

    // source over destination, then repack into the current device layout
    function automatic pixel_result_t composite_pixel(input logic [PIXEL_W-1:0] src,
                                                      input logic [PIXEL_W-1:0] dst,
                                                      input logic [OPACITY_W-1:0] op);
        pixel_result_t r;
        int unsigned   s_alpha;
        int unsigned   s_chan;
        int unsigned   d_chan;
        int unsigned   mix;
        int unsigned   keep_bits;
        logic [7:0]    kept;
        logic [31:0]   field;
        r = '0;
        s_alpha = scale_by_opacity(src[31:24], op);
        for (int ch = 0; ch < 4; ch++)
        begin
            s_chan = scale_by_opacity(src[ARGB_SHIFT[ch] +: 8], op);
            d_chan = dst[ARGB_SHIFT[ch] +: 8];
            mix = s_chan + (d_chan * (255 - s_alpha)) / 255;
            if (mix > 255)
                mix = 255;
            r.blend[ARGB_SHIFT[ch] +: 8] = mix[7:0];
            // lengths above 8 keep the whole channel
            keep_bits = (lay_len[ch] > 4'd8) ? 8 : int'(lay_len[ch]);
            kept = 8'(mix >> (8 - keep_bits));
            field = {24'd0, kept} << lay_pos[ch];
            r.dev = r.dev | field;
        end
        return r;
    endfunction

    // track a register write in the local layout copy
    function automatic void note_layout_write(input logic [CFG_INDEX_W-1:0] idx,
                                              input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_RED_LENGTH:     lay_len[CH_RED]   = data[LEN_W-1:0];
            CFG_GREEN_LENGTH:   lay_len[CH_GREEN] = data[LEN_W-1:0];
            CFG_BLUE_LENGTH:    lay_len[CH_BLUE]  = data[LEN_W-1:0];
            CFG_ALPHA_LENGTH:   lay_len[CH_ALPHA] = data[LEN_W-1:0];
            CFG_RED_POSITION:   lay_pos[CH_RED]   = data[POS_W-1:0];
            CFG_GREEN_POSITION: lay_pos[CH_GREEN] = data[POS_W-1:0];
            CFG_BLUE_POSITION:  lay_pos[CH_BLUE]  = data[POS_W-1:0];
            CFG_ALPHA_POSITION: lay_pos[CH_ALPHA] = data[POS_W-1:0];
            default: ;
        endcase
    endfunction

    // write all layout registers back to back, plus one ignored index
    task automatic apply_layout(input logic [CFG_DATA_W-1:0] vals [8]);
        logic [CFG_INDEX_W-1:0] spare;
        logic [CFG_DATA_W-1:0]  junk;
        spare = 4'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST));
        junk = 5'($urandom);
        for (int i = 0; i < 8; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index <= LAYOUT_REGS[i];
            cfg_data <= vals[i];
            @(posedge clk);
            note_layout_write(LAYOUT_REGS[i], vals[i]);
        end
        cfg_index <= spare;
        cfg_data <= junk;
        @(posedge clk);
        note_layout_write(spare, junk);
        cfg_write_en <= 1'b0;
        layouts_run++;
    endtask

    // offer one pixel transaction and record what it should produce
    task automatic offer_pixel(input logic [PIXEL_W-1:0] src,
                               input logic [PIXEL_W-1:0] dst,
                               input logic [OPACITY_W-1:0] op,
                               input bit typed,
                               input pixel_result_t given);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        source_pixel <= src;
        dest_pixel <= dst;
        opacity <= op;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_pixels.push_back(typed ? given : composite_pixel(src, dst, op));
        pixels_sent++;
    endtask

    // random pixel, mostly well-formed premultiplied sources
    task automatic pick_pixel(output logic [PIXEL_W-1:0] src,
                              output logic [PIXEL_W-1:0] dst,
                              output logic [OPACITY_W-1:0] op);
        int unsigned kind;
        logic [7:0]  a;
        kind = $urandom_range(0, 99);
        a = 8'($urandom_range(0, 255));
        if (kind < 55)
            src = {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                   8'($urandom_range(0, a))};
        else if (kind < 65)
            src = {(kind[0] ? 8'hff : 8'h00), 24'($urandom)};
        else
            src = $urandom;
        kind = $urandom_range(0, 99);
        if (kind < 15)
            op = 9'd256;
        else if (kind < 25)
            op = 9'd0;
        else if (kind < 35)
            op = 9'($urandom_range(257, 511));
        else
            op = 9'($urandom_range(0, 256));
        kind = $urandom_range(0, 99);
        if (kind < 10)
            dst = '0;
        else if (kind < 20)
            dst = '1;
        else
            dst = $urandom;
    endtask

    // wait for every outstanding pixel to come back
    task automatic drain_pixels();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, one long hold when asked
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_taken != holds_asked)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            holds_taken <= holds_taken + 1;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: blended %h device %h",
                             blended_pixel, device_pixel);
                mismatches++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (blended_pixel !== want.blend || device_pixel !== want.dev)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch: blended exp %h got %h, device exp %h got %h",
                                 want.blend, blended_pixel, want.dev, device_pixel);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timed out with %0d results outstanding", pending_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [CFG_DATA_W-1:0] layout [8];
        logic [PIXEL_W-1:0]    src;
        logic [PIXEL_W-1:0]    dst;
        logic [OPACITY_W-1:0]  op;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pixels under the reset layout
        for (int i = 0; i < N_DIRECTED; i++)
            offer_pixel(DIRECTED[i].src, DIRECTED[i].dst, DIRECTED[i].op,
                        DIRECTED[i].typed, '{DIRECTED[i].blend, DIRECTED[i].dev});

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_pixels();
            // choose the layout for this phase
            for (int i = 0; i < 4; i++)
            begin
                case (p)
                    1: begin layout[i] = 5'd0;  layout[i+4] = 5'd31; end
                    2: begin layout[i] = 5'h1f; layout[i+4] = 5'd31; end
                    4: begin layout[i] = 5'd8;  layout[i+4] = 5'd0;  end
                    default:
                    begin
                        layout[i] = 5'($urandom_range(0, 31));
                        layout[i+4] = 5'($urandom_range(0, 31));
                    end
                endcase
            end
            // 565 style layout with alpha dropped
            if (p == QUIET_PHASE)
                layout = '{5'd5, 5'd6, 5'd5, 5'd0, 5'd11, 5'd5, 5'd0, 5'd0};
            if (p != 0)
                apply_layout(layout);
            else
                holds_asked++;
            quiet = (p == QUIET_PHASE);
            for (int i = 0; i < PIXELS_PER_PHASE; i++)
            begin
                pick_pixel(src, dst, op);
                offer_pixel(src, dst, op, 1'b0, '0);
            end
        end

        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("sent %0d pixels over %0d device layouts beyond reset, %0d results checked",
                 pixels_sent, layouts_run, pixels_checked);
        $display("mismatching or unexpected results: %0d", mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/aobp_pkg.sv
sv/aobp_front.sv
sv/aobp_queue.sv
sv/aobp_back.sv
sv/argb_over_blend_and_pack.sv
sv/aobp_checker.sv
tb/sv/tb_argb_over_blend_and_pack.sv
